// ----- src/qdv_pkg.sv -----
// shared types and constants for the quadrature decoder with velocity
package qdv_pkg;

    localparam int COUNT_W = 16;
    localparam int POS_W   = 7;
    localparam int VEL_W   = 16;
    localparam int TIME_W  = 32;

    // velocity numerator: microseconds per second, fits 20 bits
    localparam int DIV_BITS  = 20;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_BITS-1:0] USEC_PER_SECOND = DIV_BITS'(1000000);

    localparam logic [DIV_BITS-1:0] VEL_POS_LIMIT = DIV_BITS'(32767);
    localparam logic [DIV_BITS-1:0] VEL_NEG_LIMIT = DIV_BITS'(32768);

    typedef struct packed {
        logic              pin_a;
        logic              pin_b;
        logic [TIME_W-1:0] timestamp_us;
        logic              motor_reverse;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0]      step_count;
        logic [POS_W-1:0]        wheel_position;
        logic                    moving_reverse;
        logic                    pattern_error;
        logic signed [VEL_W-1:0] velocity;
        logic [TIME_W-1:0]       smoothed_interval;
    } out_item_t;

    // decoded step of one pin-change event
    typedef struct packed {
        logic up;
        logic down;
        logic err;
    } step_t;

endpackage

// ----- src/qdv_if.sv -----
// valid/ready channel interfaces for pin events and results
interface qdv_in_if;
    logic               valid;
    logic               ready;
    qdv_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qdv_out_if;
    logic               valid;
    logic               ready;
    qdv_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/qdv_decode.sv -----
// quadrature pattern decode with reverse fallback on a double change
module qdv_decode (
    input  logic           prev_a,
    input  logic           prev_b,
    input  logic           pin_a,
    input  logic           pin_b,
    input  logic           motor_reverse,
    output qdv_pkg::step_t step
);
    import qdv_pkg::*;

    logic err;
    logic fwd;
    logic bwd;

    always_comb
    begin
        err = (pin_a ^ prev_a) & (pin_b ^ prev_b);
        fwd = pin_a ^ prev_b;
        bwd = pin_b ^ prev_a;
        // both pins moved while driving in reverse: trust the motor
        if (err && motor_reverse)
        begin
            fwd = 1'b0;
            bwd = 1'b1;
        end
        step.err  = err;
        step.up   = fwd;
        step.down = !fwd && bwd;
    end

endmodule

// ----- src/qdv_div.sv -----
// restoring divider: constant microseconds-per-second over the interval
module qdv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qdv_pkg::TIME_W-1:0]    divisor,
    output logic                          done,
    output logic [qdv_pkg::DIV_BITS-1:0]  quotient
);
    import qdv_pkg::*;

    localparam int PAD_W = TIME_W - DIV_BITS - 1;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0]  rem_reg, rem_next;
    logic [DIV_BITS-1:0]  quo_reg, quo_next;
    logic [TIME_W-1:0]    dvs_reg, dvs_next;

    logic [DIV_BITS:0]    trial;
    logic [TIME_W-1:0]    trial_ext;
    logic [TIME_W-1:0]    diff;
    logic                 fits;

    always_comb
    begin
        trial     = {rem_reg, USEC_PER_SECOND[cnt_reg]};
        trial_ext = {{PAD_W{1'b0}}, trial};
        fits      = trial_ext >= dvs_reg;
        diff      = trial_ext - dvs_reg;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_BITS - 1);
            rem_next  = '0;
            quo_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
            quo_next = {quo_reg[DIV_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/quadrature_decoder_with_velocity_top.sv -----
// quadrature decoder with step count, wheel position and period-based velocity
//
// pin_evt carries one pin-change event: both pin levels, a microsecond
// timestamp and the commanded motor direction. result returns exactly one
// item per event: step count, wheel position, direction, pattern error,
// velocity in positions per second and the smoothed event interval.
// both channels transfer when valid and ready are high at a clock edge.
// an event that gives no step, a zero interval or a pattern error goes
// from decode straight to the output push; otherwise velocity is computed
// by the 20-step restoring divider (one quotient bit per cycle). one
// event is in work at a time; pin_evt.ready is high only while idle, so
// a new event is not taken until the previous one is pushed out.
// the result sits in an output register, so the next event is accepted
// and decoded while the previous result waits; a stalled receiver holds
// the block only when a new result is ready to be loaded.
// reset clears all counters, the position, the interval average, the last
// timestamp and the velocity to zero; no result is pending after reset.
module quadrature_decoder_with_velocity_top #(
    parameter int POSITIONS_PER_TURN = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    qdv_in_if.sink           pin_evt,
    qdv_out_if.source        result
);
    import qdv_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(POSITIONS_PER_TURN - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_PUSH
    } state_t;

    state_t               state_reg, state_next;
    in_item_t             item_reg, item_next;
    logic                 prev_a_reg, prev_a_next;
    logic                 prev_b_reg, prev_b_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic                 direction_reg, direction_next;
    logic                 error_reg, error_next;
    logic [TIME_W-1:0]    interval_reg, interval_next;
    logic [TIME_W-1:0]    last_time_reg, last_time_next;
    logic [VEL_W-1:0]     velocity_reg, velocity_next;
    logic                 neg_reg, neg_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    step_t                step;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_BITS-1:0]  quotient;

    logic [TIME_W-1:0]    elapsed;
    logic [TIME_W+1:0]    avg_sum;
    logic [TIME_W-1:0]    avg_new;
    logic [VEL_W:0]       neg_mag;
    logic [VEL_W:0]       neg_val;

    qdv_decode u_decode (
        .prev_a        (prev_a_reg),
        .prev_b        (prev_b_reg),
        .pin_a         (item_reg.pin_a),
        .pin_b         (item_reg.pin_b),
        .motor_reverse (item_reg.motor_reverse),
        .step          (step)
    );

    qdv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (avg_new),
        .done     (div_done),
        .quotient (quotient)
    );

    assign pin_evt.ready = (state_reg == S_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    always_comb
    begin
        // 3:1 smoothing, sum kept two bits wider so the shift never loses the top
        elapsed = item_reg.timestamp_us - last_time_reg;
        avg_sum = {2'b00, interval_reg} + {1'b0, interval_reg, 1'b0} + {2'b00, elapsed};
        avg_new = avg_sum[TIME_W+1:2];

        neg_mag = (quotient > VEL_NEG_LIMIT) ? VEL_NEG_LIMIT[VEL_W:0] : quotient[VEL_W:0];
        neg_val = '0 - neg_mag;

        state_next     = state_reg;
        item_next      = item_reg;
        prev_a_next    = prev_a_reg;
        prev_b_next    = prev_b_reg;
        count_next     = count_reg;
        position_next  = position_reg;
        direction_next = direction_reg;
        error_next     = error_reg;
        interval_next  = interval_reg;
        last_time_next = last_time_reg;
        velocity_next  = velocity_reg;
        neg_next       = neg_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !result.ready;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pin_evt.valid)
                begin
                    item_next  = pin_evt.data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                error_next     = step.err;
                prev_a_next    = item_reg.pin_a;
                prev_b_next    = item_reg.pin_b;
                last_time_next = item_reg.timestamp_us;
                if (step.up)
                begin
                    count_next     = count_reg + 1'b1;
                    position_next  = (position_reg >= POS_MAX) ? '0 : position_reg + 1'b1;
                    direction_next = 1'b0;
                end
                else if (step.down)
                begin
                    count_next     = count_reg - 1'b1;
                    position_next  = (position_reg == '0) ? POS_MAX : position_reg - 1'b1;
                    direction_next = 1'b1;
                end
                state_next = S_PUSH;
                if (!step.err)
                begin
                    interval_next = avg_new;
                    if ((!step.up && !step.down) || avg_new == '0)
                    begin
                        velocity_next = '0;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        neg_next   = step.down;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        velocity_next = neg_val[VEL_W-1:0];
                    end
                    else
                    begin
                        velocity_next = (quotient > VEL_POS_LIMIT) ?
                                        VEL_POS_LIMIT[VEL_W-1:0] : quotient[VEL_W-1:0];
                    end
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_data_next.step_count        = count_reg;
                    out_data_next.wheel_position    = position_reg;
                    out_data_next.moving_reverse    = direction_reg;
                    out_data_next.pattern_error     = error_reg;
                    out_data_next.velocity          = signed'(velocity_reg);
                    out_data_next.smoothed_interval = interval_reg;
                    out_valid_next                  = 1'b1;
                    state_next                      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_a_reg    <= 1'b0;
            prev_b_reg    <= 1'b0;
            count_reg     <= '0;
            position_reg  <= '0;
            direction_reg <= 1'b0;
            error_reg     <= 1'b0;
            interval_reg  <= '0;
            last_time_reg <= '0;
            velocity_reg  <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_a_reg    <= prev_a_next;
            prev_b_reg    <= prev_b_next;
            count_reg     <= count_next;
            position_reg  <= position_next;
            direction_reg <= direction_next;
            error_reg     <= error_next;
            interval_reg  <= interval_next;
            last_time_reg <= last_time_next;
            velocity_reg  <= velocity_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    // the divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    // velocity never moves on an event with a pattern error
    a_vel_held_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(velocity_reg) |-> !error_reg)
        else $error("velocity changed on a pattern error");

    // position stays inside one revolution
    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_MAX)
        else $error("wheel position out of range");

    // a start always leads into the divide state
    a_start_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> state_reg == S_DIV)
        else $error("divider started without entering the divide state");

endmodule
